>>> sv/tun_pkg.sv
package tun_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_WIDTH_DEF   = 24;
    localparam int OUT_FRAC_BITS_DEF = 15;

    // Width of each result component.
    localparam int OUT_WIDTH = 16;

    // Control word that travels beside the data through every stage.
    typedef struct packed {
        logic       valid;
        logic       degenerate;
        logic [2:0] neg;
    } tun_ctrl_t;

endpackage

>>> sv/tun_if.sv
// Triangle channel: the three vertices of one triangle per beat.
interface tun_in_if #(
    parameter int CW = tun_pkg::COORD_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

// Normal channel: one unit normal per beat.
interface tun_out_if ();
    logic                                 valid;
    logic                                 ready;
    logic signed [tun_pkg::OUT_WIDTH-1:0] normal_x;
    logic signed [tun_pkg::OUT_WIDTH-1:0] normal_y;
    logic signed [tun_pkg::OUT_WIDTH-1:0] normal_z;
    logic                                 degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

>>> sv/tun_front.sv
// Front pipeline: edge vectors, cross product, squares, sum of squares and
// the starting remainder for the digit cells.
module tun_front #(
    parameter int CW = tun_pkg::COORD_WIDTH_DEF,
    parameter int F  = tun_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    in_valid,
    input  logic signed [CW-1:0]    a [3],
    input  logic signed [CW-1:0]    b [3],
    input  logic signed [CW-1:0]    c [3],
    output tun_pkg::tun_ctrl_t      ctrl_out,
    output logic [2*(2*CW+2)+1:0]   s_out,
    output logic signed [2*(2*CW+2)+2*F+8:0] r_out [3],
    output logic signed [2*(2*CW+2)+2*F+8:0] p_out [3]
);
    localparam int UW = CW + 1;
    localparam int PW = 2 * CW + 2;
    localparam int DW = 2 * CW + 3;
    localparam int MW = 2 * CW + 2;
    localparam int H  = (MW + 1) / 2;
    localparam int HW = MW - H;
    localparam int SW = 2 * MW + 2;
    localparam int LW = 2 * MW + 2 * F + 9;

    tun_pkg::tun_ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg;
    tun_pkg::tun_ctrl_t ctrl5_reg, ctrl6_reg, ctrl7_reg;

    logic signed [UW-1:0]   u_reg [3];
    logic signed [UW-1:0]   v_reg [3];
    logic signed [PW-1:0]   pa_reg [3];
    logic signed [PW-1:0]   pb_reg [3];
    logic signed [DW-1:0]   d [3];
    logic signed [DW-1:0]   d_abs [3];
    logic [MW-1:0]          mag_reg [3];
    logic [2*HW-1:0]        hh_reg [3];
    logic [HW+H-1:0]        hl_reg [3];
    logic [2*H-1:0]         ll_reg [3];
    logic [2*MW-1:0]        sq5_reg [3];
    logic [2*MW-1:0]        sq6_reg [3];
    logic [SW-1:0]          s6_reg;
    logic [SW-1:0]          s7_reg;
    logic signed [LW-1:0]   r7_reg [3];
    logic signed [LW-1:0]   p7_reg [3];
    logic                   zero_cross;

    // Signed difference of the two products of each cross term.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i]     = pa_reg[i] - pb_reg[i];
            d_abs[i] = d[i][DW-1] ? -d[i] : d[i];
        end
        zero_cross = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
    end

    // Control words; only these need a reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
            ctrl5_reg <= '0;
            ctrl6_reg <= '0;
            ctrl7_reg <= '0;
        end
        else if (advance)
        begin
            ctrl1_reg <= '{valid: in_valid, degenerate: 1'b0, neg: 3'b000};
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg.valid      <= ctrl2_reg.valid;
            ctrl3_reg.degenerate <= zero_cross;
            for (int i = 0; i < 3; i++)
            begin
                ctrl3_reg.neg[i] <= d[i][DW-1];
            end
            ctrl4_reg <= ctrl3_reg;
            ctrl5_reg <= ctrl4_reg;
            ctrl6_reg <= ctrl5_reg;
            ctrl7_reg <= ctrl6_reg;
        end
    end

    // Data path stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // Edge vectors.
                u_reg[i] <= UW'(b[i]) - UW'(a[i]);
                v_reg[i] <= UW'(c[i]) - UW'(a[i]);
                // Magnitude of the cross component.
                mag_reg[i] <= d_abs[i][MW-1:0];
                // Partial products of the square.
                hh_reg[i] <= mag_reg[i][MW-1:H] * mag_reg[i][MW-1:H];
                hl_reg[i] <= mag_reg[i][MW-1:H] * mag_reg[i][H-1:0];
                ll_reg[i] <= mag_reg[i][H-1:0] * mag_reg[i][H-1:0];
                sq5_reg[i] <= ((2*MW)'(hh_reg[i]) << (2 * H))
                            + ((2*MW)'(hl_reg[i]) << (H + 1))
                            + (2*MW)'(ll_reg[i]);
                sq6_reg[i] <= sq5_reg[i];
                // Starting remainder N - S and running term -S.
                r7_reg[i] <= $signed(LW'(sq6_reg[i]) << (2 * F + 2))
                           - $signed(LW'(s6_reg));
                p7_reg[i] <= -$signed(LW'(s6_reg));
            end
            // Cross product terms.
            pa_reg[0] <= u_reg[1] * v_reg[2];
            pb_reg[0] <= u_reg[2] * v_reg[1];
            pa_reg[1] <= u_reg[2] * v_reg[0];
            pb_reg[1] <= u_reg[0] * v_reg[2];
            pa_reg[2] <= u_reg[0] * v_reg[1];
            pb_reg[2] <= u_reg[1] * v_reg[0];
            // Squared length.
            s6_reg <= SW'(sq5_reg[0]) + SW'(sq5_reg[1]) + SW'(sq5_reg[2]);
            s7_reg <= s6_reg;
        end
    end

    assign ctrl_out = ctrl7_reg;
    assign s_out    = s7_reg;
    assign r_out    = r7_reg;
    assign p_out    = p7_reg;

endmodule

>>> sv/tun_cell.sv
// One digit cell: decides bit BIT of all three quotient magnitudes by a
// shift-and-subtract step on the remainder N - t^2 * S, t = 2m - 1.
module tun_cell #(
    parameter int CW  = tun_pkg::COORD_WIDTH_DEF,
    parameter int F   = tun_pkg::OUT_FRAC_BITS_DEF,
    parameter int BIT = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  tun_pkg::tun_ctrl_t      ctrl_in,
    input  logic [2*(2*CW+2)+1:0]   s_in,
    input  logic signed [2*(2*CW+2)+2*F+8:0] r_in [3],
    input  logic signed [2*(2*CW+2)+2*F+8:0] p_in [3],
    input  logic [F:0]              m_in [3],
    output tun_pkg::tun_ctrl_t      ctrl_out,
    output logic [2*(2*CW+2)+1:0]   s_out,
    output logic signed [2*(2*CW+2)+2*F+8:0] r_out [3],
    output logic signed [2*(2*CW+2)+2*F+8:0] p_out [3],
    output logic [F:0]              m_out [3]
);
    localparam int MW = 2 * CW + 2;
    localparam int LW = 2 * MW + 2 * F + 9;

    tun_pkg::tun_ctrl_t   ctrl_reg;
    logic [2*MW+1:0]      s_reg;
    logic signed [LW-1:0] r_reg [3];
    logic signed [LW-1:0] p_reg [3];
    logic [F:0]           m_reg [3];
    logic signed [LW-1:0] s_ext;
    logic signed [LW-1:0] delta [3];
    logic signed [LW-1:0] diff [3];
    logic signed [LW-1:0] r_next [3];
    logic signed [LW-1:0] p_next [3];
    logic [F:0]           m_next [3];

    // Trial step: accept the bit when the remainder stays non-negative.
    always_comb
    begin
        s_ext = $signed(LW'(s_in));
        for (int i = 0; i < 3; i++)
        begin
            delta[i] = (p_in[i] <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
            diff[i]  = r_in[i] - delta[i];
            if (!diff[i][LW-1])
            begin
                r_next[i] = diff[i];
                p_next[i] = p_in[i] + (s_ext <<< (BIT + 1));
                m_next[i] = m_in[i] | ((F+1)'(1) << BIT);
            end
            else
            begin
                r_next[i] = r_in[i];
                p_next[i] = p_in[i];
                m_next[i] = m_in[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s_reg <= s_in;
            r_reg <= r_next;
            p_reg <= p_next;
            m_reg <= m_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign s_out    = s_reg;
    assign r_out    = r_reg;
    assign p_out    = p_reg;
    assign m_out    = m_reg;

endmodule

>>> sv/triangle_unit_normal_unit.sv
// Throughput: one triangle per cycle; all stages advance together and halt
// only while the output register holds a beat that is not taken.
// Reset: rst_n clears every stage's valid bit at once; no clearing pass.
module triangle_unit_normal_unit #(
    parameter int COORD_WIDTH   = tun_pkg::COORD_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tun_in_if.sink    tri_in,
    tun_out_if.source nrm_out
);
    localparam int MW  = 2 * COORD_WIDTH + 2;
    localparam int SW  = 2 * MW + 2;
    localparam int LW  = 2 * MW + 2 * OUT_FRAC_BITS + 9;
    localparam int NC  = OUT_FRAC_BITS + 1;
    localparam int OW  = tun_pkg::OUT_WIDTH;
    localparam int EW  = (NC > OW) ? NC : OW;

    logic                           advance;
    logic signed [COORD_WIDTH-1:0]  a [3];
    logic signed [COORD_WIDTH-1:0]  b [3];
    logic signed [COORD_WIDTH-1:0]  c [3];

    tun_pkg::tun_ctrl_t   ctrl_chain [NC+1];
    logic [SW-1:0]        s_chain [NC+1];
    logic signed [LW-1:0] r_chain [NC+1][3];
    logic signed [LW-1:0] p_chain [NC+1][3];
    logic [NC-1:0]        m_chain [NC+1][3];

    logic                 out_valid_reg;
    logic signed [OW-1:0] nrm_reg [3];
    logic                 deg_reg;
    logic [OW-1:0]        nrm_next [3];
    logic [EW-1:0]        m_ext [3];
    logic [EW-1:0]        top_val;

    // The whole pipe moves unless a finished beat is held at the output.
    assign advance      = !out_valid_reg || nrm_out.ready;
    assign tri_in.ready = advance;

    assign a[0] = tri_in.a_x;
    assign a[1] = tri_in.a_y;
    assign a[2] = tri_in.a_z;
    assign b[0] = tri_in.b_x;
    assign b[1] = tri_in.b_y;
    assign b[2] = tri_in.b_z;
    assign c[0] = tri_in.c_x;
    assign c[1] = tri_in.c_y;
    assign c[2] = tri_in.c_z;

    tun_front #(
        .CW (COORD_WIDTH),
        .F  (OUT_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (tri_in.valid),
        .a        (a),
        .b        (b),
        .c        (c),
        .ctrl_out (ctrl_chain[0]),
        .s_out    (s_chain[0]),
        .r_out    (r_chain[0]),
        .p_out    (p_chain[0])
    );

    assign m_chain[0][0] = '0;
    assign m_chain[0][1] = '0;
    assign m_chain[0][2] = '0;

    // Row of digit cells, most significant bit first.
    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        tun_cell #(
            .CW  (COORD_WIDTH),
            .F   (OUT_FRAC_BITS),
            .BIT (OUT_FRAC_BITS - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .ctrl_in  (ctrl_chain[k]),
            .s_in     (s_chain[k]),
            .r_in     (r_chain[k]),
            .p_in     (p_chain[k]),
            .m_in     (m_chain[k]),
            .ctrl_out (ctrl_chain[k+1]),
            .s_out    (s_chain[k+1]),
            .r_out    (r_chain[k+1]),
            .p_out    (p_chain[k+1]),
            .m_out    (m_chain[k+1])
        );
    end

    // Sign, saturation and the degenerate case.
    always_comb
    begin
        top_val = (EW'(1) << OUT_FRAC_BITS) - EW'(1);
        for (int i = 0; i < 3; i++)
        begin
            m_ext[i] = EW'(m_chain[NC][i]);
            if (ctrl_chain[NC].degenerate)
            begin
                nrm_next[i] = '0;
            end
            else if (ctrl_chain[NC].neg[i])
            begin
                nrm_next[i] = OW'(EW'(0) - m_ext[i]);
            end
            else
            begin
                nrm_next[i] = OW'((m_ext[i] > top_val) ? top_val : m_ext[i]);
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ctrl_chain[NC].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nrm_reg[i] <= $signed(nrm_next[i]);
            end
            deg_reg <= ctrl_chain[NC].degenerate;
        end
    end

    assign nrm_out.valid      = out_valid_reg;
    assign nrm_out.normal_x   = nrm_reg[0];
    assign nrm_out.normal_y   = nrm_reg[1];
    assign nrm_out.normal_z   = nrm_reg[2];
    assign nrm_out.degenerate = deg_reg;

`ifndef SYNTHESIS
    // A degenerate triangle always leaves with a zero normal.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_out.valid && nrm_out.degenerate |->
            nrm_out.normal_x == '0 && nrm_out.normal_y == '0 &&
            nrm_out.normal_z == '0)
        else $error("degenerate beat with nonzero normal");

    // A held output beat stalls the input side.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_out.valid && !nrm_out.ready |-> !tri_in.ready)
        else $error("input accepted while output stalled");

    // A stalled output beat keeps its normal.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_out.valid && !nrm_out.ready |=>
            nrm_out.valid && $stable(nrm_out.normal_x) &&
            $stable(nrm_out.normal_y) && $stable(nrm_out.normal_z))
        else $error("output beat changed while stalled");
`endif

endmodule
